/* rtl/dhcp_client_lease_fsm_core_assert.svh */
// Assertion macros for the DHCP client lease core.
`ifndef DHCP_CLIENT_LEASE_FSM_CORE_ASSERT_SVH
`define DHCP_CLIENT_LEASE_FSM_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define DCLF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dclf assertion failed");
`define DCLF_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("dclf forbidden condition");
`else
`define DCLF_ASSERT(lbl, clk, rst_n, prop)
`define DCLF_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/dclf_pkg.sv */
`timescale 1ns / 1ps
package dclf_pkg;

    typedef enum logic [2:0] {
        ST_INIT       = 3'd0,
        ST_SELECTING  = 3'd1,
        ST_REQUESTING = 3'd2,
        ST_BOUND      = 3'd3,
        ST_RENEWING   = 3'd4,
        ST_REBINDING  = 3'd5
    } t_state;

    localparam logic [7:0]  MSG_OFFER  = 8'd2;
    localparam logic [7:0]  MSG_ACK    = 8'd5;
    localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
    localparam logic [31:0] SEC_TO_MS  = 32'd1000;
    localparam int          CFG_W      = 48;

    localparam logic [1:0] CFG_STANDALONE        = 2'd0;
    localparam logic [1:0] CFG_DISCOVER_ATTEMPTS = 2'd1;
    localparam logic [1:0] CFG_CLIENT_MAC        = 2'd2;

    localparam int OPT_TYPE   = 0;
    localparam int OPT_MASK   = 1;
    localparam int OPT_T1     = 2;
    localparam int OPT_T2     = 3;
    localparam int OPT_LEASE  = 4;
    localparam int OPT_SERVER = 5;

    typedef struct packed {
        logic        mode;
        logic [31:0] rx_xid;
        logic [47:0] rx_hw_addr;
        logic [7:0]  rx_msg_type;
        logic [31:0] rx_your_ip;
        logic [31:0] rx_subnet_mask;
        logic [31:0] rx_renew_seconds;
        logic [31:0] rx_rebind_seconds;
        logic [31:0] rx_lease_seconds;
        logic [31:0] rx_server_ip;
        logic [5:0]  options_present;
        logic [31:0] random_xid;
    } t_in_item;

    typedef struct packed {
        logic        is_reply;
        logic [31:0] rx_xid;
        logic [47:0] rx_hw_addr;
        logic [7:0]  rx_msg_type;
        logic [31:0] rx_your_ip;
        logic [31:0] rx_subnet_mask;
        logic [31:0] renew_ms;
        logic [31:0] rebind_ms;
        logic [31:0] lease_ms;
        logic [31:0] rx_server_ip;
        logic [5:0]  options_present;
        logic [31:0] random_xid;
    } t_q_item;

    typedef struct packed {
        logic        send_valid;
        logic        send_kind;
        logic        send_broadcast;
        logic [31:0] dest_ip;
        logic [31:0] send_xid;
        logic [31:0] client_ip;
        logic [31:0] requested_ip;
        logic [31:0] server_id;
        logic [2:0]  fsm_state;
        logic [7:0]  discover_left;
        logic        addr_update;
        logic [31:0] netmask;
    } t_out_item;

    typedef struct packed {
        logic valid;
    } t_q_ctl;

endpackage

/* rtl/dclf_if.sv */
`timescale 1ns / 1ps
interface dclf_in_if;
    logic                valid;
    logic                ready;
    dclf_pkg::t_in_item  data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface dclf_out_if;
    logic                valid;
    logic                ready;
    dclf_pkg::t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/dclf_front.sv */
`timescale 1ns / 1ps
module dclf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    dclf_in_if.sink            i_in,
    input  logic               i_pop,
    output logic               o_q_valid,
    output dclf_pkg::t_q_item  o_q_item
);

    dclf_pkg::t_q_item r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push;
    logic       pop;
    dclf_pkg::t_q_item entry;

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_pop && (r_count != 2'd0);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    // classify and pre-scale lease times
    always_comb begin
        entry.is_reply        = i_in.data.mode;
        entry.rx_xid          = i_in.data.rx_xid;
        entry.rx_hw_addr      = i_in.data.rx_hw_addr;
        entry.rx_msg_type     = i_in.data.rx_msg_type;
        entry.rx_your_ip      = i_in.data.rx_your_ip;
        entry.rx_subnet_mask  = i_in.data.rx_subnet_mask;
        entry.renew_ms        = 32'(i_in.data.rx_renew_seconds * dclf_pkg::SEC_TO_MS);
        entry.rebind_ms       = 32'(i_in.data.rx_rebind_seconds * dclf_pkg::SEC_TO_MS);
        entry.lease_ms        = 32'(i_in.data.rx_lease_seconds * dclf_pkg::SEC_TO_MS);
        entry.rx_server_ip    = i_in.data.rx_server_ip;
        entry.options_present = i_in.data.options_present;
        entry.random_xid      = i_in.data.random_xid;
    end

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= entry;
        end
    end

endmodule

/* rtl/dclf_back.sv */
`timescale 1ns / 1ps
`include "dhcp_client_lease_fsm_core_assert.svh"
module dclf_back #(
    parameter int RETRY_LIMIT = 4,
    parameter int TICK_MS     = 1000
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [dclf_pkg::CFG_W-1:0] i_cfg_data,
    input  dclf_pkg::t_q_ctl         i_q,
    input  dclf_pkg::t_q_item        i_q_item,
    output logic                     o_pop,
    dclf_out_if.source               o_out
);

    localparam logic [7:0]  LIMIT8 = 8'(RETRY_LIMIT);
    localparam logic [31:0] TICK32 = 32'(TICK_MS);

    logic        r_standalone;
    logic [47:0] r_mac;

    dclf_pkg::t_state r_state, n_state;
    logic [7:0]  r_disc, n_disc;
    logic [7:0]  r_retry, n_retry;
    logic [31:0] r_xid, n_xid;
    logic [31:0] r_elapsed, n_elapsed;
    logic [7:0]  r_last_type, n_last_type;
    logic [31:0] r_mask, n_mask;
    logic [31:0] r_renew, n_renew;
    logic [31:0] r_rebind, n_rebind;
    logic [31:0] r_lease, n_lease;
    logic [31:0] r_server, n_server;
    logic [31:0] r_bound, n_bound;
    logic [31:0] r_offered, n_offered;

    logic                r_out_valid;
    dclf_pkg::t_out_item r_out, n_out;

    logic        pop;
    logic        rep;
    logic [31:0] e_next;
    logic        renew_hit, rebind_hit, lease_hit;
    logic        enter_renew, at_renew, enter_rebind, at_rebind, expire;
    logic        sel_retry, req_retry, sel_timeout, req_timeout;
    logic        run_init, init_blocked, init_send;
    logic [31:0] xid_tick;
    logic        match;
    logic [7:0]  mt_new;
    logic [31:0] mask_new;
    logic        ack;

    assign pop   = i_q.valid && (!r_out_valid || o_out.ready);
    assign o_pop = pop;
    assign rep   = i_q_item.is_reply;

    assign e_next       = r_elapsed + TICK32;
    assign renew_hit    = e_next >= r_renew;
    assign rebind_hit   = e_next >= r_rebind;
    assign lease_hit    = e_next >= r_lease;
    assign enter_renew  = (r_state == dclf_pkg::ST_BOUND) && renew_hit;
    assign at_renew     = (r_state == dclf_pkg::ST_RENEWING) || enter_renew;
    assign enter_rebind = at_renew && rebind_hit;
    assign at_rebind    = (r_state == dclf_pkg::ST_REBINDING) || enter_rebind;
    assign expire       = at_rebind && lease_hit;
    assign sel_retry    = (r_state == dclf_pkg::ST_SELECTING) && (r_retry != 8'd0);
    assign req_retry    = (r_state == dclf_pkg::ST_REQUESTING) && (r_retry != 8'd0);
    assign sel_timeout  = (r_state == dclf_pkg::ST_SELECTING) && (r_retry == 8'd0);
    assign req_timeout  = (r_state == dclf_pkg::ST_REQUESTING) && (r_retry == 8'd0);
    assign run_init     = (r_state == dclf_pkg::ST_INIT) || sel_timeout || expire;
    assign init_blocked = (r_disc == 8'd0) && !r_standalone;
    assign init_send    = run_init && !init_blocked;
    assign xid_tick     = init_send ? i_q_item.random_xid
                        : r_xid + 32'(enter_renew) + 32'(enter_rebind) + 32'(req_timeout);

    assign match    = (i_q_item.rx_xid == r_xid) && (i_q_item.rx_hw_addr == r_mac);
    assign mt_new   = i_q_item.options_present[dclf_pkg::OPT_TYPE]
                    ? i_q_item.rx_msg_type : r_last_type;
    assign mask_new = i_q_item.options_present[dclf_pkg::OPT_MASK]
                    ? i_q_item.rx_subnet_mask : r_mask;
    assign ack      = (mt_new == dclf_pkg::MSG_ACK);

    // next state
    always_comb begin
        n_state     = r_state;
        n_disc      = r_disc;
        n_retry     = r_retry;
        n_xid       = r_xid;
        n_elapsed   = r_elapsed;
        n_last_type = r_last_type;
        n_mask      = r_mask;
        n_renew     = r_renew;
        n_rebind    = r_rebind;
        n_lease     = r_lease;
        n_server    = r_server;
        n_bound     = r_bound;
        n_offered   = r_offered;
        if (!rep) begin
            n_elapsed = e_next;
            n_xid     = xid_tick;
            if (sel_retry || req_retry) begin
                n_retry = r_retry - 8'd1;
            end else if (req_timeout) begin
                n_retry = LIMIT8 - 8'd1;
            end
            if (init_send) begin
                n_disc = ((r_disc == 8'd0) ? LIMIT8 : r_disc) - 8'd1;
            end
            if (expire) begin
                n_last_type = '0;
                n_mask      = '0;
                n_renew     = '0;
                n_rebind    = '0;
                n_lease     = '0;
                n_server    = '0;
            end
            if (run_init) begin
                n_state = init_blocked ? dclf_pkg::ST_INIT : dclf_pkg::ST_SELECTING;
            end else if (req_timeout) begin
                n_state = dclf_pkg::ST_SELECTING;
            end else if (at_rebind) begin
                n_state = dclf_pkg::ST_REBINDING;
            end else if (at_renew) begin
                n_state = dclf_pkg::ST_RENEWING;
            end
        end else if (match) begin
            n_last_type = mt_new;
            n_mask      = mask_new;
            if (i_q_item.options_present[dclf_pkg::OPT_T1]) n_renew = i_q_item.renew_ms;
            if (i_q_item.options_present[dclf_pkg::OPT_T2]) n_rebind = i_q_item.rebind_ms;
            if (i_q_item.options_present[dclf_pkg::OPT_LEASE]) n_lease = i_q_item.lease_ms;
            if (i_q_item.options_present[dclf_pkg::OPT_SERVER]) begin
                n_server = i_q_item.rx_server_ip;
            end
            n_offered = i_q_item.rx_your_ip;
            case (r_state)
                dclf_pkg::ST_SELECTING: begin
                    if (mt_new == dclf_pkg::MSG_OFFER) n_state = dclf_pkg::ST_REQUESTING;
                end
                dclf_pkg::ST_REQUESTING: begin
                    if (!ack) begin
                        n_state = dclf_pkg::ST_SELECTING;
                    end else begin
                        n_bound   = i_q_item.rx_your_ip;
                        n_elapsed = '0;
                        n_state   = dclf_pkg::ST_BOUND;
                    end
                end
                dclf_pkg::ST_RENEWING, dclf_pkg::ST_REBINDING: begin
                    if (!ack) begin
                        n_last_type = '0;
                        n_mask      = '0;
                        n_renew     = '0;
                        n_rebind    = '0;
                        n_lease     = '0;
                        n_server    = '0;
                        n_state     = dclf_pkg::ST_INIT;
                    end else begin
                        n_elapsed = '0;
                        n_state   = dclf_pkg::ST_BOUND;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result item
    always_comb begin
        n_out               = '0;
        n_out.fsm_state     = n_state;
        n_out.discover_left = n_disc;
        if (!rep) begin
            n_out.send_xid = xid_tick;
            if (init_send || sel_retry || req_timeout) begin
                n_out.send_valid     = 1'b1;
                n_out.send_broadcast = 1'b1;
                n_out.dest_ip        = dclf_pkg::ALL_ONES;
            end else if (req_retry) begin
                n_out.send_valid     = 1'b1;
                n_out.send_kind      = 1'b1;
                n_out.send_broadcast = 1'b1;
                n_out.dest_ip        = dclf_pkg::ALL_ONES;
                n_out.requested_ip   = r_offered;
                n_out.server_id      = r_server;
            end else if (at_renew && !rebind_hit) begin
                n_out.send_valid     = 1'b1;
                n_out.send_kind      = 1'b1;
                n_out.send_broadcast = (r_server == dclf_pkg::ALL_ONES);
                n_out.dest_ip        = r_server;
                n_out.client_ip      = r_bound;
            end else if (at_rebind && !lease_hit) begin
                n_out.send_valid     = 1'b1;
                n_out.send_kind      = 1'b1;
                n_out.send_broadcast = 1'b1;
                n_out.dest_ip        = dclf_pkg::ALL_ONES;
                n_out.client_ip      = r_bound;
            end
            if (!n_out.send_valid) begin
                n_out.send_xid = '0;
            end
        end else if (match && (r_state == dclf_pkg::ST_REQUESTING) && ack) begin
            n_out.client_ip   = i_q_item.rx_your_ip;
            n_out.addr_update = 1'b1;
            n_out.netmask     = mask_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_standalone <= 1'b1;
            r_mac        <= '0;
            r_state      <= dclf_pkg::ST_INIT;
            r_disc       <= 8'd3;
            r_retry      <= LIMIT8;
            r_xid        <= '0;
            r_elapsed    <= '0;
            r_last_type  <= '0;
            r_mask       <= '0;
            r_renew      <= '0;
            r_rebind     <= '0;
            r_lease      <= '0;
            r_server     <= '0;
            r_bound      <= '0;
            r_offered    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (pop) begin
                r_state     <= n_state;
                r_disc      <= n_disc;
                r_retry     <= n_retry;
                r_xid       <= n_xid;
                r_elapsed   <= n_elapsed;
                r_last_type <= n_last_type;
                r_mask      <= n_mask;
                r_renew     <= n_renew;
                r_rebind    <= n_rebind;
                r_lease     <= n_lease;
                r_server    <= n_server;
                r_bound     <= n_bound;
                r_offered   <= n_offered;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dclf_pkg::CFG_STANDALONE: r_standalone <= i_cfg_data[0];
                    dclf_pkg::CFG_DISCOVER_ATTEMPTS: begin
                        r_disc <= i_cfg_data[7:0];
                    end
                    dclf_pkg::CFG_CLIENT_MAC: r_mac <= i_cfg_data[47:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `DCLF_ASSERT(a_ack_binds, i_clk, i_rst_n, r_out_valid && r_out.addr_update |-> r_out.fsm_state == dclf_pkg::ST_BOUND)
    `DCLF_ASSERT(a_idle_send_zero, i_clk, i_rst_n, r_out_valid && !r_out.send_valid |-> r_out.dest_ip == 32'd0 && r_out.send_xid == 32'd0)
    `DCLF_ASSERT_NEVER(a_update_no_send, i_clk, i_rst_n, r_out_valid && r_out.addr_update && r_out.send_valid)

endmodule

/* rtl/dhcp_client_lease_fsm_core.sv */
`timescale 1ns / 1ps
// channel   dir   payload               handshake
// i_in      in    t_in_item (tick/rx)   valid/ready
// o_out     out   t_out_item (result)   valid/ready
// i_cfg_*   in    index + 48-bit data   write enable only
//
// One item per cycle while the output is not stalled: the back end computes the state update combinationally.
// An accepted item passes through the 2-entry queue and then the output register before its result appears.
// Reset clears the state to INIT with discover_left 3 and retry count RETRY_LIMIT.
// A stalled output holds the queue; input ready drops only when the queue is full.
module dhcp_client_lease_fsm_core #(
    parameter int RETRY_LIMIT = 4,
    parameter int TICK_MS     = 1000
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_idx,
    input  logic [dclf_pkg::CFG_W-1:0] i_cfg_data,
    dclf_in_if.sink                    i_in,
    dclf_out_if.source                 o_out
);

    dclf_pkg::t_q_ctl  q_ctl;
    dclf_pkg::t_q_item q_item;
    logic              q_valid;
    logic              q_pop;

    assign q_ctl.valid = q_valid;

    dclf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_pop     (q_pop),
        .o_q_valid (q_valid),
        .o_q_item  (q_item)
    );

    dclf_back #(
        .RETRY_LIMIT (RETRY_LIMIT),
        .TICK_MS     (TICK_MS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q        (q_ctl),
        .i_q_item   (q_item),
        .o_pop      (q_pop),
        .o_out      (o_out)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

    localparam int RETRY_MAX = 4;
    localparam int TICK_STEP = 1000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [1:0]      i_cfg_idx = '0;
    logic [dclf_pkg::CFG_W-1:0] i_cfg_data = '0;

    dclf_in_if  in_ch();
    dclf_out_if out_ch();

    dhcp_client_lease_fsm_core #(.RETRY_LIMIT(RETRY_MAX), .TICK_MS(TICK_STEP)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // lease client mirror
    bit        cl_standalone;
    bit [47:0] cl_mac;
    dclf_pkg::t_state cl_state;
    bit [7:0]  cl_disc, cl_retry, cl_type;
    bit [31:0] cl_xid, cl_elapsed, cl_mask, cl_renew, cl_rebind, cl_lease;
    bit [31:0] cl_server, cl_bound, cl_offered;

    dclf_pkg::t_out_item pending_results[$];
    int n_fail = 0, n_results = 0, n_sent = 0, n_replies = 0, n_updates = 0;
    bit stim_done = 0;

    function automatic void clear_opts();
        cl_type = 0; cl_mask = 0; cl_renew = 0; cl_rebind = 0; cl_lease = 0;
        cl_server = 0;
    endfunction

    function automatic void lease_reset();
        cl_standalone = 1; cl_mac = 0; cl_state = dclf_pkg::ST_INIT;
        cl_disc = 3; cl_retry = 8'(RETRY_MAX); cl_xid = 0; cl_elapsed = 0;
        cl_bound = 0; cl_offered = 0;
        clear_opts();
    endfunction

    function automatic void mark_send(ref dclf_pkg::t_out_item r, input bit kind,
                                      input bit [31:0] dest);
        r.send_valid = 1; r.send_kind = kind;
        r.send_broadcast = (dest == dclf_pkg::ALL_ONES); r.dest_ip = dest;
        r.send_xid = cl_xid;
        if (kind) begin
            if (cl_state inside {dclf_pkg::ST_BOUND, dclf_pkg::ST_RENEWING,
                                 dclf_pkg::ST_REBINDING})
                r.client_ip = cl_bound;
            else begin
                r.requested_ip = cl_offered;
                r.server_id = cl_server;
            end
        end
    endfunction

    function automatic dclf_pkg::t_out_item lease_step(dclf_pkg::t_in_item it);
        dclf_pkg::t_out_item r;
        bit again;
        r = '0;
        if (!it.mode) begin
            cl_elapsed = cl_elapsed + 32'(TICK_STEP);
            again = 1;
            while (again) begin
                again = 0;
                case (cl_state)
                    dclf_pkg::ST_INIT: begin
                        if (cl_disc == 0 && cl_standalone) cl_disc = 8'(RETRY_MAX);
                        if (cl_disc != 0) begin
                            cl_disc--;
                            cl_xid = it.random_xid;
                            mark_send(r, 0, dclf_pkg::ALL_ONES);
                            cl_state = dclf_pkg::ST_SELECTING;
                        end
                    end
                    dclf_pkg::ST_SELECTING: begin
                        if (cl_retry > 0) begin
                            cl_retry--;
                            mark_send(r, 0, dclf_pkg::ALL_ONES);
                        end else begin
                            cl_state = dclf_pkg::ST_INIT; again = 1;
                        end
                    end
                    dclf_pkg::ST_REQUESTING: begin
                        if (cl_retry > 0) begin
                            cl_retry--;
                            mark_send(r, 1, dclf_pkg::ALL_ONES);
                        end else begin
                            cl_retry = 8'(RETRY_MAX); cl_xid++;
                            cl_state = dclf_pkg::ST_SELECTING; again = 1;
                        end
                    end
                    dclf_pkg::ST_BOUND: begin
                        if (cl_elapsed >= cl_renew) begin
                            cl_xid++; cl_state = dclf_pkg::ST_RENEWING; again = 1;
                        end
                    end
                    dclf_pkg::ST_RENEWING: begin
                        if (cl_elapsed >= cl_rebind) begin
                            cl_xid++; cl_state = dclf_pkg::ST_REBINDING; again = 1;
                        end else mark_send(r, 1, cl_server);
                    end
                    dclf_pkg::ST_REBINDING: begin
                        if (cl_elapsed >= cl_lease) begin
                            clear_opts(); cl_state = dclf_pkg::ST_INIT; again = 1;
                        end else mark_send(r, 1, dclf_pkg::ALL_ONES);
                    end
                    default: ;
                endcase
            end
        end else if (it.rx_xid == cl_xid && it.rx_hw_addr == cl_mac) begin
            if (it.options_present[dclf_pkg::OPT_TYPE]) cl_type = it.rx_msg_type;
            if (it.options_present[dclf_pkg::OPT_MASK]) cl_mask = it.rx_subnet_mask;
            if (it.options_present[dclf_pkg::OPT_T1])
                cl_renew = it.rx_renew_seconds * dclf_pkg::SEC_TO_MS;
            if (it.options_present[dclf_pkg::OPT_T2])
                cl_rebind = it.rx_rebind_seconds * dclf_pkg::SEC_TO_MS;
            if (it.options_present[dclf_pkg::OPT_LEASE])
                cl_lease = it.rx_lease_seconds * dclf_pkg::SEC_TO_MS;
            if (it.options_present[dclf_pkg::OPT_SERVER]) cl_server = it.rx_server_ip;
            cl_offered = it.rx_your_ip;
            case (cl_state)
                dclf_pkg::ST_SELECTING:
                    if (cl_type == dclf_pkg::MSG_OFFER) cl_state = dclf_pkg::ST_REQUESTING;
                dclf_pkg::ST_REQUESTING: begin
                    if (cl_type != dclf_pkg::MSG_ACK) cl_state = dclf_pkg::ST_SELECTING;
                    else begin
                        cl_bound = cl_offered; r.client_ip = cl_bound;
                        r.addr_update = 1; r.netmask = cl_mask;
                        cl_elapsed = 0; cl_state = dclf_pkg::ST_BOUND;
                    end
                end
                dclf_pkg::ST_RENEWING, dclf_pkg::ST_REBINDING: begin
                    if (cl_type != dclf_pkg::MSG_ACK) begin
                        clear_opts(); cl_state = dclf_pkg::ST_INIT;
                    end else begin
                        cl_elapsed = 0; cl_state = dclf_pkg::ST_BOUND;
                    end
                end
                default: ;
            endcase
        end
        r.fsm_state = cl_state;
        r.discover_left = cl_disc;
        return r;
    endfunction

    // result checker with random stall
    initial begin : result_side
        int stall;
        dclf_pkg::t_out_item want;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            n_results++;
            if (out_ch.data.addr_update) n_updates++;
            if (out_ch.data.send_valid) n_sent++;
            if (pending_results.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected item: %p", out_ch.data);
            end else begin
                want = pending_results.pop_front();
                if (want !== out_ch.data) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch item %0d\n  exp %p\n  got %p",
                                 n_results, want, out_ch.data);
                end
            end
        end
    end

    task automatic send_item(dclf_pkg::t_in_item it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (it.mode) n_replies++;
    endtask

    task automatic push_item(dclf_pkg::t_in_item it);
        send_item(it);
        pending_results.push_back(lease_step(it));
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dclf_pkg::CFG_STANDALONE: cl_standalone = val[0];
            dclf_pkg::CFG_DISCOVER_ATTEMPTS: cl_disc = val[7:0];
            dclf_pkg::CFG_CLIENT_MAC: cl_mac = val;
            default: ;
        endcase
    endtask

    function automatic dclf_pkg::t_in_item tick_item();
        dclf_pkg::t_in_item it;
        it = '0;
        it.random_xid = $urandom;
        return it;
    endfunction

    function automatic dclf_pkg::t_in_item reply_item(bit good, bit [7:0] kind);
        dclf_pkg::t_in_item it;
        it.mode = 1;
        it.rx_xid = good ? cl_xid : $urandom;
        it.rx_hw_addr = good ? cl_mac : 48'({$urandom, $urandom});
        it.rx_msg_type = ($urandom_range(0, 5) == 0) ? 8'($urandom) : kind;
        it.rx_your_ip = $urandom;
        it.rx_subnet_mask = $urandom;
        it.rx_renew_seconds = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 6);
        it.rx_rebind_seconds = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 10);
        it.rx_lease_seconds = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 14);
        it.rx_server_ip = $urandom;
        it.options_present = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'h3F;
        it.random_xid = $urandom;
        return it;
    endfunction

    typedef struct {
        dclf_pkg::t_in_item  stim;
        bit                  fixed;
        dclf_pkg::t_out_item result;
    } t_row;

    initial begin : stimulus
        t_row      rows[$];
        t_row      row;
        dclf_pkg::t_in_item  it;
        dclf_pkg::t_out_item fx;
        int        k;
        lease_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset-time behavior, extremes, and special cases
        row.stim = tick_item(); row.stim.random_xid = 32'hFFFF_FFFF; row.fixed = 1;
        fx = '0; fx.send_valid = 1; fx.send_broadcast = 1; fx.dest_ip = dclf_pkg::ALL_ONES;
        fx.send_xid = 32'hFFFF_FFFF; fx.fsm_state = dclf_pkg::ST_SELECTING;
        fx.discover_left = 2;
        row.result = fx; rows.push_back(row);
        row.fixed = 0;
        row.stim = '1; rows.push_back(row);            // mismatched reply
        foreach (rows[i]) begin
            if (rows[i].fixed) begin
                void'(lease_step(rows[i].stim));
                pending_results.push_back(rows[i].result);
                send_item(rows[i].stim);
            end else push_item(rows[i].stim);
        end
        // retry exhaustion in SELECTING back to INIT with new xid
        for (k = 0; k < 6; k++) push_item(tick_item());
        push_item(reply_item(1, dclf_pkg::MSG_OFFER));
        it = reply_item(1, dclf_pkg::MSG_OFFER); it.options_present = 6'h3E; push_item(it);
        for (k = 0; k < 6; k++) push_item(tick_item());   // SELECTING timeouts back to INIT
        push_item(reply_item(1, dclf_pkg::MSG_OFFER));
        it = reply_item(1, dclf_pkg::MSG_ACK); it.options_present = 6'h3F;
        it.rx_renew_seconds = 1; it.rx_rebind_seconds = 2; it.rx_lease_seconds = 3;
        push_item(it);
        for (k = 0; k < 4; k++) push_item(tick_item());   // chained expiry
        drain();

        write_reg(dclf_pkg::CFG_CLIENT_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(dclf_pkg::CFG_STANDALONE, 48'd0);
        write_reg(dclf_pkg::CFG_DISCOVER_ATTEMPTS, 48'd1);
        for (k = 0; k < 12; k++) push_item(tick_item());  // one discover send, then blocked in INIT
        drain();
        write_reg(dclf_pkg::CFG_DISCOVER_ATTEMPTS, 48'd255);

        for (k = 0; k < 1020; k++) begin
            if (k == 340) begin
                drain();
                write_reg(dclf_pkg::CFG_STANDALONE, 48'd1);
                write_reg(dclf_pkg::CFG_CLIENT_MAC, 48'({$urandom, $urandom}));
                write_reg(dclf_pkg::CFG_DISCOVER_ATTEMPTS, 48'd0);
            end else if (k == 700) begin
                drain();
                write_reg(dclf_pkg::CFG_CLIENT_MAC, 48'h0);
                write_reg(dclf_pkg::CFG_DISCOVER_ATTEMPTS, 48'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_item(tick_item());
                4: push_item(reply_item(1'($urandom_range(0, 1)), 8'($urandom)));
                5, 6: push_item(reply_item(1, dclf_pkg::MSG_OFFER));
                default: push_item(reply_item(1, dclf_pkg::MSG_ACK));
            endcase
        end
        drain();
        stim_done = 1;
    end

    initial begin : finisher
        wait (stim_done);
        $display("%0d results checked; %0d replies, %0d sends, %0d address binds",
                 n_results, n_replies, n_sent, n_updates);
        if (n_fail == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #500000;
        $display("timeout");
        $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/dclf_pkg.sv
rtl/dclf_if.sv
rtl/dclf_front.sv
rtl/dclf_back.sv
rtl/dhcp_client_lease_fsm_core.sv
tb/sv/tb_top.sv
